@@ rtl/fmr_pkg.sv @@
// ----------------------------------------------------------------------------
// fmr_pkg
// shared types for the fraction multiply and reduce block
// ----------------------------------------------------------------------------
package fmr_pkg;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 31;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture inputs
    logic mul;       // register products
    logic prep;      // set up gcd operands
    logic gcd_init;  // start one remainder step
    logic gcd_step;  // one restoring division bit
    logic gcd_swap;  // a <= b, b <= rem
    logic div_init;  // start quotient division
    logic div_step;  // one quotient bit for both products
    logic fin;       // form result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reduce;    // reduction needed
    logic b_zero;    // gcd second operand is zero
    logic cnt_done;  // bit counter expired
  } sts_t;

endpackage

@@ rtl/fmr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fmr_ctrl
// sequencer for load, multiply, gcd, divide and output
// ----------------------------------------------------------------------------
module fmr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  fmr_pkg::sts_t  sts,
  output fmr_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    IDLE  = 9'b000000001,
    MUL   = 9'b000000010,
    PREP  = 9'b000000100,
    GTEST = 9'b000001000,
    GDIV  = 9'b000010000,
    DINIT = 9'b000100000,
    DDIV  = 9'b001000000,
    FIN   = 9'b010000000,
    OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = (state == IDLE);
    m_tvalid = (state == OUT);
    case (state)
      IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = MUL;
      end
      MUL: begin
        cmd.mul = 1'b1;
        state_next = PREP;
      end
      PREP: begin
        cmd.prep = 1'b1;
        state_next = GTEST;
      end
      GTEST: begin
        if (!sts.reduce) begin
          state_next = FIN;
        end else if (sts.b_zero) begin
          state_next = DINIT;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next = GDIV;
        end
      end
      GDIV: begin
        cmd.gcd_step = 1'b1;
        if (sts.cnt_done) begin
          cmd.gcd_swap = 1'b1;
          state_next = GTEST;
        end
      end
      DINIT: begin
        cmd.div_init = 1'b1;
        state_next = DDIV;
      end
      DDIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_done) state_next = FIN;
      end
      FIN: begin
        cmd.fin = 1'b1;
        state_next = OUT;
      end
      OUT: begin
        if (m_tready) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == OUT) && !m_tready |=> (state == OUT))
    else $error("result dropped while stalled");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while result pending");
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == MUL))
    else $error("load not followed by multiply");

endmodule

@@ rtl/fmr_dp.sv @@
// ----------------------------------------------------------------------------
// fmr_dp
// products, bit-serial euclid gcd and shared bit-serial divider
// ----------------------------------------------------------------------------
module fmr_dp #(
  parameter int IN_WIDTH = 16
) (
  input  logic                          clk,
  input  fmr_pkg::cmd_t                 cmd,
  output fmr_pkg::sts_t                 sts,
  input  logic [4*IN_WIDTH-1:0]         din,
  output logic [fmr_pkg::NUM_W-1:0]     prod_num,
  output logic [fmr_pkg::DEN_W-1:0]     prod_den
);

  localparam int PW = 2 * IN_WIDTH;          // product magnitude width
  localparam int CW = $clog2(PW + 1);
  // sign is applied at the wider of product and output width
  localparam int XW = (PW > int'(fmr_pkg::NUM_W)) ? PW : int'(fmr_pkg::NUM_W);

  logic signed [IN_WIDTH-1:0] na, da, nb, db;
  logic signed [PW-1:0] p, q;
  logic pneg, qneg, reduce;
  logic [PW-1:0] pm, qm, ga, gb, rem, quo, rem2, quo2;
  logic [CW-1:0] cnt;
  logic [PW:0] t1, t2;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na <= din[IN_WIDTH-1:0];
      da <= din[2*IN_WIDTH-1:IN_WIDTH];
      nb <= din[3*IN_WIDTH-1:2*IN_WIDTH];
      db <= din[4*IN_WIDTH-1:3*IN_WIDTH];
    end
  end

  // one restoring step each for the two remainder chains
  assign t1 = {rem, quo[PW-1]} - {1'b0, gb};
  assign t2 = {rem2, quo2[PW-1]} - {1'b0, gb};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p <= PW'(na * nb);
      q <= PW'(da * db);
    end
    if (cmd.prep) begin
      pneg <= p[PW-1];
      qneg <= q[PW-1];
      pm <= p[PW-1] ? PW'(-p) : p;
      qm <= q[PW-1] ? PW'(-q) : q;
      ga <= p[PW-1] ? PW'(-p) : p;
      gb <= q[PW-1] ? PW'(-q) : q;
      // min(p,q) nonzero
      reduce <= (p < q) ? (p != '0) : (q != '0);
    end
    if (cmd.gcd_init) begin
      rem <= '0;
      quo <= ga;
      cnt <= CW'(PW);
    end
    if (cmd.div_init) begin
      gb <= ga;  // gcd now in ga, use as divisor
      rem <= '0;
      quo <= pm;
      rem2 <= '0;
      quo2 <= qm;
      cnt <= CW'(PW);
    end
    if (cmd.gcd_step || cmd.div_step) begin
      cnt <= cnt - 1'b1;
      if (!t1[PW]) rem <= t1[PW-1:0];
      else rem <= {rem[PW-2:0], quo[PW-1]};
      quo <= {quo[PW-2:0], !t1[PW]};
      if (!t2[PW]) rem2 <= t2[PW-1:0];
      else rem2 <= {rem2[PW-2:0], quo2[PW-1]};
      quo2 <= {quo2[PW-2:0], !t2[PW]};
    end
    if (cmd.gcd_swap) begin
      ga <= gb;
      gb <= !t1[PW] ? t1[PW-1:0] : {rem[PW-2:0], quo[PW-1]};
    end
    if (cmd.fin) begin
      logic [PW-1:0] fn, fd;
      logic [XW-1:0] fx;
      logic sn;
      fn = reduce ? quo : pm;
      fd = reduce ? quo2 : qm;
      fx = XW'(fn);
      sn = pneg ^ qneg;
      prod_num <= fmr_pkg::NUM_W'(sn ? -fx : fx);
      prod_den <= fmr_pkg::DEN_W'(fd);
    end
  end

  assign sts.reduce = reduce;
  assign sts.b_zero = (gb == '0);
  assign sts.cnt_done = (cnt == CW'(1));

endmodule

@@ rtl/fraction_multiply_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_multiply_reduce
// multiplies two signed fractions and reduces the product by its gcd
// ----------------------------------------------------------------------------
// usage
//   s_ side takes one word: num_a, den_a, num_b, den_b (two's complement)
//   m_ side gives one word: reduced prod_num (signed) and prod_den (>= 0)
//   one item at a time: s_tready is high only while the block is idle
//   with no reduction the word passes the MUL, PREP, GTEST and FIN states
//   before m_tvalid; with reduction each euclid remainder step and the
//   final quotient pair add a pass of the bit-serial restoring divider
//   the next word is taken only after the result has been accepted
//   no reduction when the smaller signed product is zero
//   a negative denominator flips both signs; a zero denominator passes
//   reset returns the controller to idle with no result pending
//   while m_tready is low the result is held and no new word is taken
// ----------------------------------------------------------------------------
module fraction_multiply_reduce #(
  parameter int IN_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // num_a, den_a, num_b, den_b from bit 0 up
  input  logic [((4*IN_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // prod_num[31:0], prod_den[62:32], zero pad
  output logic [63:0]           m_tdata
);

  fmr_pkg::cmd_t cmd;
  fmr_pkg::sts_t sts;
  logic [fmr_pkg::NUM_W-1:0] prod_num;
  logic [fmr_pkg::DEN_W-1:0] prod_den;

  fmr_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .sts, .cmd
  );

  fmr_dp #(.IN_WIDTH(IN_WIDTH)) u_dp (
    .clk, .cmd, .sts,
    .din(s_tdata[4*IN_WIDTH-1:0]),
    .prod_num, .prod_den
  );

  assign m_tdata = {1'b0, prod_den, prod_num};

endmodule
